// File: sv/positional_insert_queue_defines.svh
// assertion macros for the positional insert queue
// used by the top level only, no other dependencies
`ifndef POSITIONAL_INSERT_QUEUE_DEFINES_SVH
`define POSITIONAL_INSERT_QUEUE_DEFINES_SVH
`ifndef ASSERT_OFF
// condition that must hold at every clock edge out of reset
`define PIQ_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// implication checked out of reset
`define PIQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication failed");
`else
`define PIQ_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define PIQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/piq_pkg.sv
// types and constants for the positional insert queue
// no dependencies
`timescale 1ns / 1ps
package piq_pkg;
	localparam int QUEUE_DEPTH = 16;
	localparam int WORD_W      = 32;
	localparam int COUNT_W     = 5;
	localparam int OPC_W       = 2;
	localparam int STAT_W      = 2;

	typedef enum logic [OPC_W-1:0] {
		OP_INSERT  = 2'd0,
		OP_APPEND  = 2'd1,
		OP_EXTRACT = 2'd2
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	typedef struct packed {
		logic [OPC_W-1:0]          opcode;
		logic signed [WORD_W-1:0]  data_word;
		logic [COUNT_W-1:0]        position;
	} in_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0]  out_word;
		logic [STAT_W-1:0]         status;
		logic [COUNT_W-1:0]        occupancy;
	} out_item_t;
endpackage

// File: sv/piq_in_if.sv
// operation channel of the positional insert queue
// depends on piq_pkg
`timescale 1ns / 1ps
interface piq_in_if import piq_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// File: sv/piq_out_if.sv
// result channel of the positional insert queue
// depends on piq_pkg
`timescale 1ns / 1ps
interface piq_out_if import piq_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// File: sv/positional_insert_queue.sv
// pipeline: an operation is held in the operation register, its result in the result register
// throughput: one operation per cycle while the result channel does not stall; all entries shift in parallel
// reset: arst_n clears the occupancy and both valid flags; entry words stay undefined
// depends on piq_pkg, piq_in_if, piq_out_if and positional_insert_queue_defines.svh
`timescale 1ns / 1ps
`include "positional_insert_queue_defines.svh"
module positional_insert_queue import piq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	piq_in_if.sink     in_ch,
	piq_out_if.source  out_ch
);
	// operation register
	in_item_t  op_s1;
	logic      op_valid_s1;
	// result register
	out_item_t res_s2;
	logic      res_valid_s2;

	// queue storage: entry 0 is the head
	logic signed [WORD_W-1:0] entry_q [QUEUE_DEPTH];
	logic signed [WORD_W-1:0] entry_d [QUEUE_DEPTH];
	logic [COUNT_W-1:0]       count_q;
	logic [COUNT_W-1:0]       count_d;

	logic      advance;     // result register free to take a new result
	logic      compute;     // operation in s1 executes this cycle
	logic      is_full;
	logic      is_empty;
	logic      do_insert;
	logic      do_append;
	logic      do_extract;
	out_item_t res_d;

	// the result register drains or is empty, so s1 may move on
	assign advance     = !res_valid_s2 || out_ch.ready;
	assign compute     = op_valid_s1 && advance;
	assign in_ch.ready = !op_valid_s1 || advance;

	assign is_full  = (count_q == COUNT_W'(QUEUE_DEPTH));
	assign is_empty = (count_q == '0);

	// decode the operation and its status
	always_comb begin
		do_insert  = 1'b0;
		do_append  = 1'b0;
		do_extract = 1'b0;
		res_d.out_word = '0;
		res_d.status   = ST_OK;
		unique case (op_s1.opcode)
			OP_INSERT: begin
				// full wins over a bad position
				if (is_full) begin
					res_d.status = ST_FULL;
				end else if (op_s1.position > count_q) begin
					res_d.status = ST_BADPOS;
				end else begin
					do_insert = 1'b1;
				end
			end
			OP_APPEND: begin
				if (is_full) begin
					res_d.status = ST_FULL;
				end else begin
					do_append = 1'b1;
				end
			end
			OP_EXTRACT: begin
				if (is_empty) begin
					res_d.status = ST_EMPTY;
				end else begin
					do_extract     = 1'b1;
					res_d.out_word = entry_q[0];
				end
			end
			default: begin
				// unused opcode: no operation, ok status
				res_d.status = ST_OK;
			end
		endcase
		count_d = count_q;
		if (do_insert || do_append) begin
			count_d = count_q + 1'b1;
		end else if (do_extract) begin
			count_d = count_q - 1'b1;
		end
		res_d.occupancy = count_d;
	end

	// next value of every entry, each picks from itself, a neighbour or the new word
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			entry_d[i] = entry_q[i];
		end
		if (do_extract) begin
			for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
				entry_d[i] = entry_q[i+1];
			end
		end else if (do_insert) begin
			// entries from the position onward move back by one
			for (int i = 1; i < QUEUE_DEPTH; i++) begin
				if (COUNT_W'(i) > op_s1.position) begin
					entry_d[i] = entry_q[i-1];
				end
			end
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				if (COUNT_W'(i) == op_s1.position) begin
					entry_d[i] = op_s1.data_word;
				end
			end
		end else if (do_append) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				if (COUNT_W'(i) == count_q) begin
					entry_d[i] = op_s1.data_word;
				end
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_valid_s1  <= 1'b0;
			res_valid_s2 <= 1'b0;
			count_q      <= '0;
		end else begin
			if (in_ch.ready) begin
				op_valid_s1 <= in_ch.valid;
			end
			if (advance) begin
				res_valid_s2 <= op_valid_s1;
			end
			if (compute) begin
				count_q <= count_d;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			op_s1 <= in_ch.payload;
		end
		if (compute) begin
			res_s2 <= res_d;
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				entry_q[i] <= entry_d[i];
			end
		end
	end

	assign out_ch.valid   = res_valid_s2;
	assign out_ch.payload = res_s2;

	// checks on the queue logic
	`PIQ_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= COUNT_W'(QUEUE_DEPTH), "occupancy beyond depth")
	`PIQ_ASSERT_IMPLY(a_occ_tracks, clk, arst_n, res_valid_s2, res_s2.occupancy == count_q)
	`PIQ_ASSERT_IMPLY(a_word_only_ok, clk, arst_n, res_valid_s2 && res_s2.out_word != '0, res_s2.status == ST_OK)
	`PIQ_ASSERT_IMPLY(a_extract_dec, clk, arst_n, $past(compute && do_extract), count_q == $past(count_q) - 1'b1)
endmodule

// File: tb/positional_insert_queue_checker.sv
// transfer monitor and result checker for the positional insert queue
// depends on piq_pkg, piq_in_if and piq_out_if
`timescale 1ns / 1ps
module positional_insert_queue_checker import piq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	piq_in_if    in_ch,
	piq_out_if   out_ch,
	output int   pending_count,
	output int   fail_count
);

	// shadow copy of the queue contents, head at index 0
	logic signed [WORD_W-1:0] shadow_words [QUEUE_DEPTH];
	int                       shadow_count = 0;
	out_item_t                awaited_results [$];
	int                       errors = 0;

	// applies one operation to the shadow queue and returns its result
	function automatic out_item_t queue_op_result(in_item_t op);
		out_item_t res;
		int        i;
		res.out_word = '0;
		res.status   = ST_OK;
		case (op.opcode)
			OP_INSERT: begin
				if (shadow_count >= QUEUE_DEPTH) begin
					res.status = ST_FULL;
				end else if (int'(op.position) > shadow_count) begin
					res.status = ST_BADPOS;
				end else begin
					for (i = shadow_count; i > int'(op.position); i--)
						shadow_words[i] = shadow_words[i-1];
					shadow_words[op.position] = op.data_word;
					shadow_count++;
				end
			end
			OP_APPEND: begin
				if (shadow_count >= QUEUE_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					shadow_words[shadow_count] = op.data_word;
					shadow_count++;
				end
			end
			OP_EXTRACT: begin
				if (shadow_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.out_word = shadow_words[0];
					for (i = 1; i < shadow_count; i++)
						shadow_words[i-1] = shadow_words[i];
					shadow_count--;
				end
			end
			default: ;
		endcase
		res.occupancy = shadow_count[COUNT_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		out_item_t got;
		if (!arst_n) begin
			shadow_count = 0;
			awaited_results.delete();
		end else begin
			if (in_ch.valid && in_ch.ready)
				awaited_results.push_back(queue_op_result(in_ch.payload));
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.payload;
				if (awaited_results.size() == 0) begin
					$display("%0t: result with none awaited: word %0d status %0d occupancy %0d",
						$time, got.out_word, got.status, got.occupancy);
					errors++;
				end else begin
					want = awaited_results.pop_front();
					if (got.out_word !== want.out_word) begin
						$display("%0t: out_word expected %0d actual %0d",
							$time, want.out_word, got.out_word);
						errors++;
					end
					if (got.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, got.status);
						errors++;
					end
					if (got.occupancy !== want.occupancy) begin
						$display("%0t: occupancy expected %0d actual %0d",
							$time, want.occupancy, got.occupancy);
						errors++;
					end
				end
			end
		end
		pending_count <= awaited_results.size();
		fail_count    <= errors;
	end

endmodule

// File: tb/positional_insert_queue_tb.sv
// top level of the positional insert queue testbench: clock, reset, stimulus and verdict
// depends on piq_pkg, piq_in_if, piq_out_if, the block and positional_insert_queue_checker
`timescale 1ns / 1ps
module positional_insert_queue_tb;
	import piq_pkg::*;

	// opcode value the block must treat as a no-op
	localparam logic [OPC_W-1:0] OPC_UNUSED = 2'd3;
	// cycles the receiver refuses every transfer to back the block up
	localparam int LONG_HOLD = 40;
	// items per idling phase of the random part
	localparam int PHASE_ITEMS = 400;
	// cycles allowed after the last result, well over the two-stage latency
	localparam int DRAIN_CYCLES = 8;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	piq_in_if  in_ch ();
	piq_out_if out_ch ();

	int pending_count;
	int fail_count;

	// percentages steering the idling of both sides
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	// long receiver hold-offs: requested by the sender process, served by the receiver
	int holds_asked = 0;
	int holds_done = 0;
	int hold_cycles = 0;
	// occupancy as the stimulus sees it, used to aim insert positions and to fill the queue
	int occ_est = 0;

	positional_insert_queue u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	positional_insert_queue_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_ch         (in_ch),
		.out_ch        (out_ch),
		.pending_count (pending_count),
		.fail_count    (fail_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit, far beyond the slowest correct run
	initial begin
		#400000;
		$display("positional_insert_queue_tb: errors");
		$finish;
	end

	// word source with the extremes mixed in often
	function automatic logic signed [WORD_W-1:0] random_word();
		case ($urandom_range(15))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return '0;
			3:       return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// offers one operation, idling first at the sender's rate, and returns after its transfer
	task automatic send_op(input logic [OPC_W-1:0] opc, input logic signed [WORD_W-1:0] word,
			input logic [COUNT_W-1:0] pos);
		in_item_t item;
		item.opcode    = opc;
		item.data_word = word;
		item.position  = pos;
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.payload <= item;
		do @(posedge clk); while (!in_ch.ready);
		// keep the position aim in step with the queue
		if (opc == OP_INSERT && occ_est < QUEUE_DEPTH && int'(pos) <= occ_est)
			occ_est++;
		else if (opc == OP_APPEND && occ_est < QUEUE_DEPTH)
			occ_est++;
		else if (opc == OP_EXTRACT && occ_est > 0)
			occ_est--;
	endtask

	// one random operation; add_pct is the chance of an insert or an append
	task automatic random_op(input int add_pct);
		int pick;
		logic [COUNT_W-1:0] pos;
		pick = $urandom_range(99);
		if ($urandom_range(99) < 85)
			pos = COUNT_W'($urandom_range(occ_est > 16 ? 16 : occ_est, 0));
		else
			pos = COUNT_W'($urandom_range(31, 0));
		if (pick < 3)
			send_op(OPC_UNUSED, random_word(), pos);
		else if (pick < 3 + add_pct)
			send_op($urandom_range(1) ? OP_INSERT : OP_APPEND, random_word(), pos);
		else
			send_op(OP_EXTRACT, random_word(), pos);
	endtask

	// receiver side: random stalls, or a long counted hold-off when one is asked for
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_asked != holds_done) begin
				out_ch.ready <= 1'b0;
				hold_cycles++;
				if (hold_cycles == LONG_HOLD) begin
					hold_cycles = 0;
					holds_done++;
				end
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// sender side and verdict
	initial begin
		int phase;
		int sent;
		int burst_len;
		int add_pct;
		int i;
		in_ch.valid   <= 1'b0;
		in_ch.payload <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty queue, positions at the edges, no-op opcode
		send_op(OP_EXTRACT, 32'sh1234_5678, 5'd0);   // extract from empty
		send_op(OP_INSERT, 32'sd7, 5'd1);            // empty queue, position past the tail
		send_op(OP_INSERT, 32'sh7fff_ffff, 5'd0);    // empty queue takes an insert at the head
		send_op(OP_APPEND, 32'sh8000_0000, 5'd31);   // append ignores the position
		send_op(OP_INSERT, -32'sd1, 5'd0);           // new head
		send_op(OP_INSERT, 32'sd0, 5'd3);            // position equal to the occupancy: tail
		send_op(OP_INSERT, 32'sh5a5a_a5a5, 5'd2);    // middle of the queue
		send_op(OP_INSERT, 32'sd99, 5'd31);          // position far beyond the occupancy
		send_op(OPC_UNUSED, -32'sd1, 5'd31);         // unused opcode leaves everything alone
		send_op(OP_EXTRACT, 32'sd0, 5'd0);           // head comes back
		// fill to capacity, then knock on a full queue
		while (occ_est < QUEUE_DEPTH)
			send_op(OP_APPEND, random_word(), 5'd0);
		send_op(OP_APPEND, 32'sd1, 5'd0);            // full
		send_op(OP_INSERT, 32'sd2, 5'd16);           // full, valid-looking tail position
		send_op(OP_INSERT, 32'sd3, 5'd31);           // full outranks bad position

		// random part, one idling pattern per phase
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
				default: begin send_idle_pct = 21; recv_stall_pct = 21; end
			endcase
			// first burst of the run drains what the directed part left behind
			add_pct = (phase == 0) ? 10 : 50;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				burst_len = $urandom_range(30, 6);
				for (i = 0; i < burst_len; i++) begin
					random_op(add_pct);
					sent++;
					// receiver holds off while the sender keeps offering
					if (phase == 0 && sent == 200)
						holds_asked++;
					// sender stands back until every result is home
					if (phase == 2 && sent == 200) begin
						in_ch.valid <= 1'b0;
						do @(posedge clk); while (pending_count != 0);
					end
				end
				// next burst fills, drains or mixes
				case ($urandom_range(2))
					0:       add_pct = 85;
					1:       add_pct = 15;
					default: add_pct = 50;
				endcase
			end
		end
		in_ch.valid <= 1'b0;

		// let every awaited result arrive, then watch for strays
		do @(posedge clk); while (pending_count != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("positional_insert_queue_tb: clean");
		else
			$display("positional_insert_queue_tb: errors");
		$finish;
	end

endmodule
